>>> rtl/sci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sci_pkg: shared types and saturating helpers
// 64-bit signed fixed-point helpers and the payload records that travel with
// each request through the arithmetic units.
// ----------------------------------------------------------------------------
package sci_pkg;

	localparam int IW              = 64;
	localparam int COORD_BITS_DEF  = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int SLACK_BITS      = 16;
	localparam logic [SLACK_BITS-1:0] SLACK_RESET = 16'd66;

	typedef logic signed [IW-1:0] fix_t;

	localparam fix_t SMAX = {1'b0, {(IW-1){1'b1}}};
	localparam fix_t SMIN = {1'b1, {(IW-1){1'b0}}};

	// request context that rides along the whole pipeline
	typedef struct packed {
		fix_t cx;
		fix_t cy;
		fix_t sx;
		fix_t xmin;
		fix_t xmax;
		fix_t ylo;
		fix_t yhi;
		logic vert;
	} ctx_t;

	typedef struct packed {
		ctx_t ctx;
		fix_t px;
		fix_t py;
		fix_t dx;
		fix_t dy;
	} t1_t;

	typedef struct packed {
		ctx_t ctx;
		fix_t px;
		fix_t py;
		fix_t rr;
		fix_t dv;
	} t2_t;

	typedef struct packed {
		ctx_t ctx;
		fix_t py;
		fix_t rr;
		fix_t dv;
		fix_t slope;
	} t3_t;

	typedef struct packed {
		ctx_t ctx;
		fix_t dv;
		fix_t slope;
		fix_t e;
		fix_t norm;
	} t4_t;

	typedef struct packed {
		ctx_t ctx;
		fix_t slope;
		fix_t e;
		fix_t norm;
		fix_t nae;
		logic dneg;
	} t5_t;

	typedef struct packed {
		ctx_t ctx;
		fix_t slope;
		fix_t e;
		fix_t s;
		logic dneg;
	} t6_t;

	typedef struct packed {
		ctx_t ctx;
		fix_t e;
		fix_t s;
		fix_t u1;
		fix_t u2;
		logic dneg;
	} t7_t;

	function automatic logic [IW-1:0] mag(fix_t x);
		return x[IW-1] ? IW'(-x) : x;
	endfunction

	function automatic fix_t signed_sat(logic neg, logic [IW-1:0] m);
		if (!neg)
			return m[IW-1] ? SMAX : fix_t'(m);
		if (m[IW-1])
			return SMIN;
		return fix_t'(-m);
	endfunction

	function automatic fix_t sadd(fix_t a, fix_t b);
		logic [IW:0] s;
		s = {a[IW-1], a} + {b[IW-1], b};
		if (s[IW] != s[IW-1])
			return s[IW] ? SMIN : SMAX;
		return fix_t'(s[IW-1:0]);
	endfunction

	function automatic fix_t ssub(fix_t a, fix_t b);
		logic [IW:0] s;
		s = {a[IW-1], a} - {b[IW-1], b};
		if (s[IW] != s[IW-1])
			return s[IW] ? SMIN : SMAX;
		return fix_t'(s[IW-1:0]);
	endfunction

endpackage
`default_nettype wire

>>> rtl/sci_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sci_mul: pipelined saturating fixed-point multiplier
// Three stages: magnitudes, 32x32 partial products, combine and saturate.
// ----------------------------------------------------------------------------
module sci_mul #(
	parameter int FRAC_BITS = sci_pkg::FRAC_BITS_DEF,
	parameter int LANES     = 1,
	parameter int TAG_BITS  = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  sci_pkg::fix_t [LANES-1:0]     op_a,
	input  sci_pkg::fix_t [LANES-1:0]     op_b,
	input  logic [TAG_BITS-1:0]           tag_in,
	output logic                          out_valid,
	output sci_pkg::fix_t [LANES-1:0]     prod,
	output logic [TAG_BITS-1:0]           tag_out
);

	localparam int W = sci_pkg::IW;
	localparam int H = W / 2;

	logic                      v_s1, v_s2;
	logic [LANES-1:0][W-1:0]   ma_s1, mb_s1;
	logic [LANES-1:0]          neg_s1, neg_s2;
	logic [LANES-1:0][3:0][W-1:0] pp_s2;
	logic [TAG_BITS-1:0]       tag_s1, tag_s2;

	function automatic sci_pkg::fix_t finish(logic neg, logic [3:0][W-1:0] pp);
		logic [2*W-1:0] p;
		logic [W-1:0]   m;
		p = (2*W)'(pp[0]) + ((2*W)'(pp[1]) << H) + ((2*W)'(pp[2]) << H)
			+ ((2*W)'(pp[3]) << W);
		if ((p >> (W + FRAC_BITS)) != '0)
			m = '1;
		else
			m = p[W+FRAC_BITS-1 -: W];
		return sci_pkg::signed_sat(neg, m);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				ma_s1[l]    <= sci_pkg::mag(op_a[l]);
				mb_s1[l]    <= sci_pkg::mag(op_b[l]);
				neg_s1[l]   <= op_a[l][W-1] ^ op_b[l][W-1];
				pp_s2[l][0] <= ma_s1[l][H-1:0] * mb_s1[l][H-1:0];
				pp_s2[l][1] <= ma_s1[l][H-1:0] * mb_s1[l][W-1:H];
				pp_s2[l][2] <= ma_s1[l][W-1:H] * mb_s1[l][H-1:0];
				pp_s2[l][3] <= ma_s1[l][W-1:H] * mb_s1[l][W-1:H];
				neg_s2[l]   <= neg_s1[l];
				prod[l]     <= finish(neg_s2[l], pp_s2[l]);
			end
			tag_s1  <= tag_in;
			tag_s2  <= tag_s1;
			tag_out <= tag_s2;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sci_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sci_div: pipelined saturating fixed-point divider
// Restoring division, one quotient bit per stage; zero divisor gives zero.
// ----------------------------------------------------------------------------
module sci_div #(
	parameter int FRAC_BITS = sci_pkg::FRAC_BITS_DEF,
	parameter int LANES     = 1,
	parameter int TAG_BITS  = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  sci_pkg::fix_t [LANES-1:0]     num,
	input  sci_pkg::fix_t [LANES-1:0]     den,
	input  logic [TAG_BITS-1:0]           tag_in,
	output logic                          out_valid,
	output sci_pkg::fix_t [LANES-1:0]     quo,
	output logic [TAG_BITS-1:0]           tag_out
);

	localparam int W  = sci_pkg::IW;
	localparam int QB = W + FRAC_BITS;

	logic [LANES-1:0][QB-1:0] n_r   [QB+1];
	logic [LANES-1:0][QB-1:0] q_r   [QB+1];
	logic [LANES-1:0][W-1:0]  ub_r  [QB+1];
	logic [LANES-1:0][W-1:0]  rem_r [QB+1];
	logic [LANES-1:0]         neg_r [QB+1];
	logic [LANES-1:0]         dz_r  [QB+1];
	logic [TAG_BITS-1:0]      t_r   [QB+1];
	logic                     v_r   [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++)
				v_r[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_r[0] <= in_valid;
			for (int k = 1; k <= QB; k++)
				v_r[k] <= v_r[k-1];
			out_valid <= v_r[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				n_r[0][l]   <= {sci_pkg::mag(num[l]), {FRAC_BITS{1'b0}}};
				ub_r[0][l]  <= sci_pkg::mag(den[l]);
				rem_r[0][l] <= '0;
				q_r[0][l]   <= '0;
				neg_r[0][l] <= num[l][W-1] ^ den[l][W-1];
				dz_r[0][l]  <= (den[l] == '0);
			end
			t_r[0] <= tag_in;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [LANES-1:0][W:0] rt;
		logic [LANES-1:0]      ge;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				rt[l] = {rem_r[k-1][l], n_r[k-1][l][QB-1]};
				ge[l] = rt[l] >= {1'b0, ub_r[k-1][l]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem_r[k][l] <= ge[l] ? W'(rt[l] - {1'b0, ub_r[k-1][l]}) : rt[l][W-1:0];
					q_r[k][l]   <= {q_r[k-1][l][QB-2:0], ge[l]};
					n_r[k][l]   <= n_r[k-1][l] << 1;
					ub_r[k][l]  <= ub_r[k-1][l];
					neg_r[k][l] <= neg_r[k-1][l];
					dz_r[k][l]  <= dz_r[k-1][l];
				end
				t_r[k] <= t_r[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				if (dz_r[QB][l])
					quo[l] <= '0;
				else if ((q_r[QB][l] >> (W - 1)) != '0)
					quo[l] <= sci_pkg::signed_sat(neg_r[QB][l], '1);
				else
					quo[l] <= sci_pkg::signed_sat(neg_r[QB][l], q_r[QB][l][W-1:0]);
			end
			tag_out <= t_r[QB];
		end
	end

endmodule
`default_nettype wire

>>> rtl/sci_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sci_sqrt: pipelined fixed-point square root
// Digit-by-digit integer root of (v << FRAC_BITS) | ones, one bit per stage.
// ----------------------------------------------------------------------------
module sci_sqrt #(
	parameter int FRAC_BITS = sci_pkg::FRAC_BITS_DEF,
	parameter int TAG_BITS  = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  sci_pkg::fix_t        radicand,
	input  logic [TAG_BITS-1:0]  tag_in,
	output logic                 out_valid,
	output sci_pkg::fix_t        root,
	output logic [TAG_BITS-1:0]  tag_out
);

	localparam int W  = sci_pkg::IW;
	localparam int SB = (W + FRAC_BITS) / 2;
	localparam int MB = 2 * SB;
	localparam int RW = SB + 3;

	logic [MB-1:0]       m_r    [SB+1];
	logic [RW-1:0]       rem_r  [SB+1];
	logic [SB-1:0]       root_r [SB+1];
	logic [TAG_BITS-1:0] t_r    [SB+1];
	logic                v_r    [SB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SB; k++)
				v_r[k] <= 1'b0;
		end else if (en) begin
			v_r[0] <= in_valid;
			for (int k = 1; k <= SB; k++)
				v_r[k] <= v_r[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_r[0]    <= (radicand > 0) ? MB'({radicand[W-2:0], {FRAC_BITS{1'b1}}}) : '0;
			rem_r[0]  <= '0;
			root_r[0] <= '0;
			t_r[0]    <= tag_in;
		end
	end

	for (genvar k = 1; k <= SB; k++) begin : g_step
		logic [RW-1:0] rt, trial;
		logic          ge;

		always_comb begin
			rt    = {rem_r[k-1][RW-3:0], m_r[k-1][MB-1 -: 2]};
			trial = RW'({root_r[k-1], 2'b01});
			ge    = rt >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[k]  <= ge ? rt - trial : rt;
				root_r[k] <= {root_r[k-1][SB-2:0], ge};
				m_r[k]    <= m_r[k-1] << 2;
				t_r[k]    <= t_r[k-1];
			end
		end
	end

	assign out_valid = v_r[SB];
	assign root      = sci_pkg::fix_t'(root_r[SB]);
	assign tag_out   = t_r[SB];

endmodule
`default_nettype wire

>>> rtl/segment_circle_intersect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_circle_intersect: segment / circle meeting point
// Finds one point where a segment meets a circle, in signed fixed point, as a
// fully pipelined datapath that takes one request per cycle while not stalled.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------
//   cfg      | in        | cfg_valid/cfg_ready | cfg_data (bound_slack)
//   in       | in        | in_valid/in_ready   | seg_start_x/y, seg_delta_x/y,
//            |           |                     | circle_x/y, circle_radius
//   out      | out       | out_valid/out_ready | hit, point_x, point_y
//
// One request enters every cycle while the output is not stalled. The depth
// is set mostly by the two bit-serial divider pipelines (slope, then root
// offsets) and the square-root pipeline.
// Reset clears only the valid bits and sets bound_slack to 66.
// A stall at the output freezes every stage at once, so nothing is lost or
// repeated; cfg writes are taken in any cycle.
// ----------------------------------------------------------------------------
module segment_circle_intersect #(
	parameter int COORD_BITS = sci_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sci_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sci_pkg::SLACK_BITS-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        seg_start_x,
	input  logic signed [COORD_BITS-1:0]        seg_start_y,
	input  logic signed [COORD_BITS-1:0]        seg_delta_x,
	input  logic signed [COORD_BITS-1:0]        seg_delta_y,
	input  logic signed [COORD_BITS-1:0]        circle_x,
	input  logic signed [COORD_BITS-1:0]        circle_y,
	input  logic [COORD_BITS-2:0]               circle_radius,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic signed [COORD_BITS-1:0]        point_x,
	output logic signed [COORD_BITS-1:0]        point_y
);

	localparam sci_pkg::fix_t FIX_ONE = sci_pkg::fix_t'(1) <<< FRAC_BITS;
	localparam sci_pkg::fix_t CMAX    = (sci_pkg::fix_t'(1) <<< (COORD_BITS - 1)) - 1;
	localparam sci_pkg::fix_t CMIN    = -CMAX - 1;

	logic en;
	logic [sci_pkg::SLACK_BITS-1:0] bound_slack_q;

	// advance the whole pipeline unless the output holds a request not yet taken
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bound_slack_q <= sci_pkg::SLACK_RESET;
		else if (cfg_valid)
			bound_slack_q <= cfg_data;
	end

	// ---- stage 1: widen inputs, offsets, end point and bounds -------------
	sci_pkg::fix_t sx, sy, dx, dy, ex, ey;
	sci_pkg::t1_t  t1_d, t1_s1;
	sci_pkg::fix_t r_s1;
	logic          v_s1;

	always_comb begin
		sx = sci_pkg::fix_t'(seg_start_x);
		sy = sci_pkg::fix_t'(seg_start_y);
		dx = sci_pkg::fix_t'(seg_delta_x);
		dy = sci_pkg::fix_t'(seg_delta_y);
		ex = sci_pkg::sadd(sx, dx);
		ey = sci_pkg::sadd(sy, dy);
		t1_d.ctx.cx   = sci_pkg::fix_t'(circle_x);
		t1_d.ctx.cy   = sci_pkg::fix_t'(circle_y);
		t1_d.ctx.sx   = sx;
		t1_d.ctx.xmin = (sx < ex) ? sx : ex;
		t1_d.ctx.xmax = (sx < ex) ? ex : sx;
		t1_d.ctx.ylo  = (sy < ey) ? sy : ey;
		t1_d.ctx.yhi  = (sy < ey) ? ey : sy;
		t1_d.ctx.vert = (dx == '0);
		t1_d.px = sci_pkg::ssub(sx, sci_pkg::fix_t'(circle_x));
		t1_d.py = sci_pkg::ssub(sy, sci_pkg::fix_t'(circle_y));
		t1_d.dx = dx;
		t1_d.dy = dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1 <= t1_d;
			r_s1  <= sci_pkg::fix_t'(circle_radius);
		end
	end

	// ---- r^2 and px^2 --------------------------------------------------------
	logic                        m1_v;
	sci_pkg::fix_t [1:0]         m1_p;
	logic [$bits(sci_pkg::t1_t)-1:0] m1_tag;
	sci_pkg::t1_t                t1_o;

	sci_mul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_BITS($bits(sci_pkg::t1_t))) u_mul_r (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.op_a({t1_s1.px, r_s1}), .op_b({t1_s1.px, r_s1}), .tag_in(t1_s1),
		.out_valid(m1_v), .prod(m1_p), .tag_out(m1_tag)
	);
	assign t1_o = m1_tag;

	// ---- slope = dy / dx ------------------------------------------------------
	sci_pkg::t2_t  t2_i, t2_o;
	logic          d1_v;
	sci_pkg::fix_t [0:0] d1_q;
	logic [$bits(sci_pkg::t2_t)-1:0] d1_tag;

	always_comb begin
		t2_i.ctx = t1_o.ctx;
		t2_i.px  = t1_o.px;
		t2_i.py  = t1_o.py;
		t2_i.rr  = m1_p[0];
		t2_i.dv  = sci_pkg::ssub(m1_p[0], m1_p[1]);
	end

	sci_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .TAG_BITS($bits(sci_pkg::t2_t))) u_div_slope (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(m1_v),
		.num(t1_o.dy), .den(t1_o.dx), .tag_in(t2_i),
		.out_valid(d1_v), .quo(d1_q), .tag_out(d1_tag)
	);
	assign t2_o = d1_tag;

	// ---- slope*px and slope^2 ------------------------------------------------
	sci_pkg::t3_t  t3_i, t3_o;
	logic          m2_v;
	sci_pkg::fix_t [1:0] m2_p;
	logic [$bits(sci_pkg::t3_t)-1:0] m2_tag;

	always_comb begin
		t3_i.ctx   = t2_o.ctx;
		t3_i.py    = t2_o.py;
		t3_i.rr    = t2_o.rr;
		t3_i.dv    = t2_o.dv;
		t3_i.slope = d1_q[0];
	end

	sci_mul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_BITS($bits(sci_pkg::t3_t))) u_mul_slope (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(d1_v),
		.op_a({d1_q[0], d1_q[0]}), .op_b({d1_q[0], t2_o.px}), .tag_in(t3_i),
		.out_valid(m2_v), .prod(m2_p), .tag_out(m2_tag)
	);
	assign t3_o = m2_tag;

	// ---- intercept e, norm A, then r^2*A, e^2, slope*e ----------------------
	sci_pkg::t4_t  t4_i, t4_o;
	logic          m3_v;
	sci_pkg::fix_t [2:0] m3_p;
	logic [$bits(sci_pkg::t4_t)-1:0] m3_tag;

	always_comb begin
		t4_i.ctx   = t3_o.ctx;
		t4_i.dv    = t3_o.dv;
		t4_i.slope = t3_o.slope;
		t4_i.e     = sci_pkg::ssub(t3_o.py, m2_p[0]);
		t4_i.norm  = sci_pkg::sadd(m2_p[1], FIX_ONE);
	end

	sci_mul #(.FRAC_BITS(FRAC_BITS), .LANES(3), .TAG_BITS($bits(sci_pkg::t4_t))) u_mul_disc (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(m2_v),
		.op_a({t4_i.slope, t4_i.e, t3_o.rr}), .op_b({t4_i.e, t4_i.e, t4_i.norm}),
		.tag_in(t4_i), .out_valid(m3_v), .prod(m3_p), .tag_out(m3_tag)
	);
	assign t4_o = m3_tag;

	// ---- square root of the discriminant (shared by both cases) -------------
	sci_pkg::t5_t  t5_i, t5_o;
	sci_pkg::fix_t disc;
	logic          sq_v;
	sci_pkg::fix_t sq_r;
	logic [$bits(sci_pkg::t5_t)-1:0] sq_tag;

	always_comb begin
		// pick the vertical-line discriminant when dx is zero
		disc        = t4_o.ctx.vert ? t4_o.dv : sci_pkg::ssub(m3_p[0], m3_p[1]);
		t5_i.ctx    = t4_o.ctx;
		t5_i.slope  = t4_o.slope;
		t5_i.e      = t4_o.e;
		t5_i.norm   = t4_o.norm;
		t5_i.nae    = sci_pkg::ssub('0, m3_p[2]);
		t5_i.dneg   = disc[sci_pkg::IW-1];
	end

	sci_sqrt #(.FRAC_BITS(FRAC_BITS), .TAG_BITS($bits(sci_pkg::t5_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(m3_v),
		.radicand(disc), .tag_in(t5_i),
		.out_valid(sq_v), .root(sq_r), .tag_out(sq_tag)
	);
	assign t5_o = sq_tag;

	// ---- root offsets u = (-a*e +- s) / A -----------------------------------
	sci_pkg::t6_t  t6_i, t6_o;
	logic          d2_v;
	sci_pkg::fix_t [1:0] d2_q;
	logic [$bits(sci_pkg::t6_t)-1:0] d2_tag;

	always_comb begin
		t6_i.ctx   = t5_o.ctx;
		t6_i.slope = t5_o.slope;
		t6_i.e     = t5_o.e;
		t6_i.s     = sq_r;
		t6_i.dneg  = t5_o.dneg;
	end

	sci_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_BITS($bits(sci_pkg::t6_t))) u_div_root (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sq_v),
		.num({sci_pkg::ssub(t5_o.nae, sq_r), sci_pkg::sadd(t5_o.nae, sq_r)}),
		.den({t5_o.norm, t5_o.norm}), .tag_in(t6_i),
		.out_valid(d2_v), .quo(d2_q), .tag_out(d2_tag)
	);
	assign t6_o = d2_tag;

	// ---- slope*u for both roots ----------------------------------------------
	sci_pkg::t7_t  t7_i, t7_o;
	logic          m4_v;
	sci_pkg::fix_t [1:0] m4_p;
	logic [$bits(sci_pkg::t7_t)-1:0] m4_tag;

	always_comb begin
		t7_i.ctx  = t6_o.ctx;
		t7_i.e    = t6_o.e;
		t7_i.s    = t6_o.s;
		t7_i.u1   = d2_q[0];
		t7_i.u2   = d2_q[1];
		t7_i.dneg = t6_o.dneg;
	end

	sci_mul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_BITS($bits(sci_pkg::t7_t))) u_mul_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(d2_v),
		.op_a({t6_o.slope, t6_o.slope}), .op_b({d2_q[1], d2_q[0]}), .tag_in(t7_i),
		.out_valid(m4_v), .prod(m4_p), .tag_out(m4_tag)
	);
	assign t7_o = m4_tag;

	// ---- stage 2: candidate points and widened box ---------------------------
	sci_pkg::fix_t slack;
	sci_pkg::fix_t x1_s2, x2_s2, y1_s2, y2_s2, vy1_s2, vy2_s2;
	sci_pkg::fix_t xlo_s2, xhi_s2, bylo_s2, byhi_s2, ylo_s2, yhi_s2, sx_s2;
	logic          vert_s2, dneg_s2, v_s2;

	assign slack = sci_pkg::fix_t'(bound_slack_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s2      <= m4_v;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2   <= sci_pkg::sadd(t7_o.ctx.cx, t7_o.u1);
			x2_s2   <= sci_pkg::sadd(t7_o.ctx.cx, t7_o.u2);
			y1_s2   <= sci_pkg::sadd(t7_o.ctx.cy, sci_pkg::sadd(m4_p[0], t7_o.e));
			y2_s2   <= sci_pkg::sadd(t7_o.ctx.cy, sci_pkg::sadd(m4_p[1], t7_o.e));
			vy1_s2  <= sci_pkg::sadd(t7_o.ctx.cy, t7_o.s);
			vy2_s2  <= sci_pkg::ssub(t7_o.ctx.cy, t7_o.s);
			xlo_s2  <= sci_pkg::ssub(t7_o.ctx.xmin, slack);
			xhi_s2  <= sci_pkg::sadd(t7_o.ctx.xmax, slack);
			bylo_s2 <= sci_pkg::ssub(t7_o.ctx.ylo, slack);
			byhi_s2 <= sci_pkg::sadd(t7_o.ctx.yhi, slack);
			ylo_s2  <= t7_o.ctx.ylo;
			yhi_s2  <= t7_o.ctx.yhi;
			sx_s2   <= t7_o.ctx.sx;
			vert_s2 <= t7_o.ctx.vert;
			dneg_s2 <= t7_o.dneg;
		end
	end

	// ---- stage 3: pick the first root on the segment, clamp, output ---------
	logic          hit_d;
	sci_pkg::fix_t rx_d, ry_d, cx_d, cy_d;

	always_comb begin
		hit_d = 1'b0;
		rx_d  = '0;
		ry_d  = '0;
		if (!dneg_s2) begin
			if (vert_s2) begin
				if (vy1_s2 >= ylo_s2 && vy1_s2 <= yhi_s2) begin
					hit_d = 1'b1;
					rx_d  = sx_s2;
					ry_d  = vy1_s2;
				end else if (vy2_s2 >= ylo_s2 && vy2_s2 <= yhi_s2) begin
					hit_d = 1'b1;
					rx_d  = sx_s2;
					ry_d  = vy2_s2;
				end
			end else begin
				if (x1_s2 >= xlo_s2 && x1_s2 <= xhi_s2 &&
				    y1_s2 >= bylo_s2 && y1_s2 <= byhi_s2) begin
					hit_d = 1'b1;
					rx_d  = x1_s2;
					ry_d  = y1_s2;
				end else if (x1_s2 != x2_s2 && x2_s2 >= xlo_s2 && x2_s2 <= xhi_s2 &&
				             y2_s2 >= bylo_s2 && y2_s2 <= byhi_s2) begin
					// try the second root only when it is a distinct point
					hit_d = 1'b1;
					rx_d  = x2_s2;
					ry_d  = y2_s2;
				end
			end
		end
		// clamp into the coordinate range
		cx_d = (rx_d > CMAX) ? CMAX : ((rx_d < CMIN) ? CMIN : rx_d);
		cy_d = (ry_d > CMAX) ? CMAX : ((ry_d < CMIN) ? CMIN : ry_d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit     <= hit_d;
			point_x <= cx_d[COORD_BITS-1:0];
			point_y <= cy_d[COORD_BITS-1:0];
		end
	end

endmodule
`default_nettype wire
